// File: sv/ppp_pkg.sv
// package: beat types, pipeline side-band types and saturation helper
`timescale 1ns / 1ps
`default_nettype none
package ppp_pkg;

  localparam logic OP_LINE   = 1'b0;
  localparam logic OP_CIRCLE = 1'b1;

  // largest circle offset magnitude, 2^33
  localparam logic [33:0] CLAMP_Q = 34'h2_0000_0000;

  typedef struct packed {
    logic               op;
    logic signed [31:0] shape_a;
    logic signed [31:0] shape_b;
    logic signed [31:0] shape_c;
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
  } ppp_in_t;

  typedef struct packed {
    logic signed [31:0] proj_x;
    logic signed [31:0] proj_y;
    logic               proj_valid;
  } ppp_out_t;

  // side-band carried beside the root and divider stages
  typedef struct packed {
    logic               op;
    logic signed [31:0] line_x;
    logic signed [31:0] line_y;
    logic signed [31:0] cen_x;
    logic signed [31:0] cen_y;
    logic               neg_x;
    logic               neg_y;
    logic               shr;
    logic [63:0]        num_x;
    logic [63:0]        num_y;
  } ppp_tag_t;

  typedef struct packed {
    logic [33:0] q_x;
    logic [33:0] q_y;
    logic        ovf_x;
    logic        ovf_y;
    logic        inval;
  } ppp_quo_t;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > 64'sd2147483647) begin
      r = 32'sh7fff_ffff;
    end else if (v < -64'sd2147483648) begin
      r = 32'sh8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// File: sv/ppp_front.sv
// front pipeline: line products and circle vector, squares and numerators
`timescale 1ns / 1ps
`default_nettype none
module ppp_front import ppp_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        en,
  input  logic        vin,
  input  ppp_in_t     din,
  output logic        vout,
  output ppp_tag_t    tag,
  output logic [63:0] sq
);

  function automatic logic signed [47:0] rnd16(input logic signed [63:0] p);
    logic signed [63:0] tmp;
    tmp = p + 64'sd32768;
    return tmp[63:16];
  endfunction

  // stage 1
  logic               v1, op1;
  logic signed [31:0] a1, b1, c1;
  logic signed [63:0] m_bpx, m_apy, m_ac, m_bc;
  logic signed [32:0] vx1, vy1;
  // stage 2
  logic               v2, op2, shr2, negx2, negy2;
  logic signed [31:0] a2, b2, t2;
  logic signed [47:0] ac2, bc2;
  logic [32:0]        ux2, uy2;
  logic [31:0]        hx2, hy2, rmag2;
  // stage 3
  logic               v3, op3, shr3, negx3, negy3, uxt3, uyt3;
  logic signed [31:0] a3, b3;
  logic signed [47:0] ac3, bc3;
  logic signed [63:0] m_bt, m_at;
  logic [63:0]        hxx, hyy, nxl, nyl;
  logic [31:0]        rmag3;
  // stage 2 combinational
  logic [32:0]        ux, uy;
  logic               shr;
  logic signed [63:0] tdiff;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0; v2 <= 1'b0; v3 <= 1'b0; vout <= 1'b0;
    end else if (en) begin
      v1 <= vin; v2 <= v1; v3 <= v2; vout <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      op1   <= din.op;
      a1    <= din.shape_a;
      b1    <= din.shape_b;
      c1    <= din.shape_c;
      m_bpx <= din.shape_b * din.point_x;
      m_apy <= din.shape_a * din.point_y;
      m_ac  <= din.shape_a * din.shape_c;
      m_bc  <= din.shape_b * din.shape_c;
      vx1   <= 33'(din.point_x) - 33'(din.shape_a);
      vy1   <= 33'(din.point_y) - 33'(din.shape_b);
    end
  end

  always_comb begin
    ux    = vx1[32] ? 33'(-vx1) : 33'(vx1);
    uy    = vy1[32] ? 33'(-vy1) : 33'(vy1);
    shr   = ux[32] | ux[31] | uy[32] | uy[31];
    tdiff = 64'(rnd16(m_bpx)) - 64'(rnd16(m_apy));
  end

  always_ff @(posedge clk) begin
    if (en) begin
      op2   <= op1;
      a2    <= a1;
      b2    <= b1;
      t2    <= sat32(tdiff);
      ac2   <= rnd16(m_ac);
      bc2   <= rnd16(m_bc);
      ux2   <= ux;
      uy2   <= uy;
      shr2  <= shr;
      hx2   <= shr ? ux[32:1] : ux[31:0];
      hy2   <= shr ? uy[32:1] : uy[31:0];
      rmag2 <= c1[31] ? 32'(-c1) : 32'(c1);
      negx2 <= vx1[32] ^ c1[31];
      negy2 <= vy1[32] ^ c1[31];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      op3   <= op2;
      a3    <= a2;
      b3    <= b2;
      ac3   <= ac2;
      bc3   <= bc2;
      m_bt  <= b2 * t2;
      m_at  <= a2 * t2;
      hxx   <= hx2 * hx2;
      hyy   <= hy2 * hy2;
      nxl   <= ux2[31:0] * rmag2;
      nyl   <= uy2[31:0] * rmag2;
      uxt3  <= ux2[32];
      uyt3  <= uy2[32];
      rmag3 <= rmag2;
      shr3  <= shr2;
      negx3 <= negx2;
      negy3 <= negy2;
    end
  end

  // offset of 2^32 leaves the low product at zero, so the top bit adds r<<32
  always_ff @(posedge clk) begin
    if (en) begin
      tag.op     <= op3;
      tag.line_x <= sat32(64'(ac3) + 64'(rnd16(m_bt)));
      tag.line_y <= sat32(64'(bc3) - 64'(rnd16(m_at)));
      tag.cen_x  <= a3;
      tag.cen_y  <= b3;
      tag.neg_x  <= negx3;
      tag.neg_y  <= negy3;
      tag.shr    <= shr3;
      tag.num_x  <= nxl + (uxt3 ? {rmag3, 32'd0} : 64'd0);
      tag.num_y  <= nyl + (uyt3 ? {rmag3, 32'd0} : 64'd0);
      sq         <= hxx + hyy;
    end
  end

endmodule
`default_nettype wire

// File: sv/ppp_isqrt.sv
// pipelined integer square root, one result bit per stage
`timescale 1ns / 1ps
`default_nettype none
module ppp_isqrt import ppp_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        en,
  input  logic        vin,
  input  logic [63:0] sq,
  input  ppp_tag_t    tag_in,
  output logic        vout,
  output logic [31:0] root,
  output ppp_tag_t    tag_out
);

  localparam int Steps = 32;

  logic [63:0] rem [0:Steps];
  logic [63:0] res [0:Steps];
  ppp_tag_t    tg  [0:Steps];
  logic        vld [0:Steps];

  assign rem[0] = sq;
  assign res[0] = '0;
  assign tg[0]  = tag_in;
  assign vld[0] = vin;

  for (genvar k = 0; k < Steps; k++) begin : g_step
    localparam logic [63:0] Bit = 64'd1 << (62 - 2 * k);
    logic [63:0] trial;
    assign trial = res[k] + Bit;

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k+1] <= 1'b0;
      end else if (en) begin
        vld[k+1] <= vld[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        if (rem[k] >= trial) begin
          rem[k+1] <= rem[k] - trial;
          res[k+1] <= (res[k] >> 1) + Bit;
        end else begin
          rem[k+1] <= rem[k];
          res[k+1] <= res[k] >> 1;
        end
        tg[k+1] <= tg[k];
      end
    end
  end

  assign vout    = vld[Steps];
  assign root    = res[Steps][31:0];
  assign tag_out = tg[Steps];

endmodule
`default_nettype wire

// File: sv/ppp_div.sv
// distance check and pipelined restoring divider for both offsets
`timescale 1ns / 1ps
`default_nettype none
module ppp_div import ppp_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        en,
  input  logic        vin,
  input  logic [31:0] root,
  input  ppp_tag_t    tag_in,
  input  logic [16:0] min_distance,
  output logic        vout,
  output ppp_quo_t    quo,
  output ppp_tag_t    tag_out
);

  localparam int Steps = 34;

  logic [32:0] dd  [0:Steps];
  logic [32:0] rx  [0:Steps];
  logic [32:0] ry  [0:Steps];
  logic [33:0] lx  [0:Steps];
  logic [33:0] ly  [0:Steps];
  logic [33:0] qx  [0:Steps];
  logic [33:0] qy  [0:Steps];
  logic        ox  [0:Steps];
  logic        oy  [0:Steps];
  logic        inv [0:Steps];
  ppp_tag_t    tg  [0:Steps];
  logic        vld [0:Steps];

  logic [32:0] d0;
  logic [63:0] nx, ny;

  // divisor and rounded numerators, half the divisor added
  always_comb begin
    d0 = tag_in.shr ? {root, 1'b0} : {1'b0, root};
    nx = tag_in.num_x + 64'(d0[32:1]);
    ny = tag_in.num_y + 64'(d0[32:1]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else if (en) begin
      vld[0] <= vin;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dd[0]  <= d0;
      rx[0]  <= {3'd0, nx[63:34]};
      ry[0]  <= {3'd0, ny[63:34]};
      lx[0]  <= nx[33:0];
      ly[0]  <= ny[33:0];
      qx[0]  <= '0;
      qy[0]  <= '0;
      ox[0]  <= {3'd0, nx[63:34]} >= d0;
      oy[0]  <= {3'd0, ny[63:34]} >= d0;
      inv[0] <= (d0 == '0) || (d0 < {16'd0, min_distance});
      tg[0]  <= tag_in;
    end
  end

  for (genvar j = 0; j < Steps; j++) begin : g_step
    logic [33:0] tx, ty, sx, sy;
    logic        gx, gy;
    always_comb begin
      tx = {rx[j], lx[j][33]};
      ty = {ry[j], ly[j][33]};
      gx = tx >= {1'b0, dd[j]};
      gy = ty >= {1'b0, dd[j]};
      sx = tx - {1'b0, dd[j]};
      sy = ty - {1'b0, dd[j]};
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[j+1] <= 1'b0;
      end else if (en) begin
        vld[j+1] <= vld[j];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        dd[j+1]  <= dd[j];
        rx[j+1]  <= gx ? sx[32:0] : tx[32:0];
        ry[j+1]  <= gy ? sy[32:0] : ty[32:0];
        lx[j+1]  <= {lx[j][32:0], 1'b0};
        ly[j+1]  <= {ly[j][32:0], 1'b0};
        qx[j+1]  <= {qx[j][32:0], gx};
        qy[j+1]  <= {qy[j][32:0], gy};
        ox[j+1]  <= ox[j];
        oy[j+1]  <= oy[j];
        inv[j+1] <= inv[j];
        tg[j+1]  <= tg[j];
      end
    end
  end

  assign vout      = vld[Steps];
  assign quo.q_x   = qx[Steps];
  assign quo.q_y   = qy[Steps];
  assign quo.ovf_x = ox[Steps];
  assign quo.ovf_y = oy[Steps];
  assign quo.inval = inv[Steps];
  assign tag_out   = tg[Steps];

`ifndef SYNTHESIS
  // remainder stays below the divisor when the quotient fits
  a_rem_below_div: assert property (@(posedge clk) disable iff (rst)
    vout && !ox[Steps] && !oy[Steps] && (dd[Steps] != '0)
      |-> (rx[Steps] < dd[Steps]) && (ry[Steps] < dd[Steps]))
    else $error("divider remainder not below divisor");
`endif

endmodule
`default_nettype wire

// File: sv/ppp_back.sv
// output stage: offset clamp, centre add, saturation and mode select
`timescale 1ns / 1ps
`default_nettype none
module ppp_back import ppp_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     en,
  input  logic     vin,
  input  ppp_quo_t quo,
  input  ppp_tag_t tag,
  output logic     vout,
  output ppp_out_t data
);

  logic [33:0]        qcx, qcy;
  logic signed [63:0] sx, sy;

  always_comb begin
    qcx = (quo.ovf_x || (quo.q_x > CLAMP_Q)) ? CLAMP_Q : quo.q_x;
    qcy = (quo.ovf_y || (quo.q_y > CLAMP_Q)) ? CLAMP_Q : quo.q_y;
    sx  = tag.neg_x ? 64'(tag.cen_x) - signed'(64'(qcx)) : 64'(tag.cen_x) + signed'(64'(qcx));
    sy  = tag.neg_y ? 64'(tag.cen_y) - signed'(64'(qcy)) : 64'(tag.cen_y) + signed'(64'(qcy));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vout <= 1'b0;
    end else if (en) begin
      vout <= vin;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (tag.op == OP_LINE) begin
        data.proj_x     <= tag.line_x;
        data.proj_y     <= tag.line_y;
        data.proj_valid <= 1'b1;
      end else if (quo.inval) begin
        data.proj_x     <= '0;
        data.proj_y     <= '0;
        data.proj_valid <= 1'b0;
      end else begin
        data.proj_x     <= sat32(sx);
        data.proj_y     <= sat32(sy);
        data.proj_valid <= 1'b1;
      end
    end
  end

`ifndef SYNTHESIS
  a_inval_zero: assert property (@(posedge clk) disable iff (rst)
    vout && !data.proj_valid |-> (data.proj_x == '0) && (data.proj_y == '0))
    else $error("invalid projection with non-zero coordinates");
  a_line_valid: assert property (@(posedge clk) disable iff (rst)
    en && vin && (tag.op == OP_LINE) |=> data.proj_valid)
    else $error("line projection flagged invalid");
`endif

endmodule
`default_nettype wire

// File: sv/project_point_onto_line_or_circle.sv
// throughput: one beat per cycle unless stalled; depth set by the 32-step root and 34-step divider
// the whole pipeline advances together and holds while the result beat waits
// reset (rst, synchronous): clears every stage valid, min_distance returns to 1
// configuration is taken at any edge with cfg_wr_en high and rst low
`timescale 1ns / 1ps
`default_nettype none
module project_point_onto_line_or_circle import ppp_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  ppp_in_t     in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output ppp_out_t    out_data,
  input  logic        cfg_wr_en,
  input  logic [16:0] cfg_wr_data
);

  // distance threshold, unsigned q1.16
  logic [16:0] min_distance;

  // pipeline advance: the output register is empty or being taken
  logic        en;

  logic        f_vld, s_vld, d_vld;
  ppp_tag_t    f_tag, s_tag, d_tag;
  logic [63:0] f_sq;
  logic [31:0] s_root;
  ppp_quo_t    d_quo;

  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_distance <= 17'd1;
    end else if (cfg_wr_en) begin
      min_distance <= cfg_wr_data;
    end
  end

  // line products and circle vector, squared length and numerators
  ppp_front u_front (
    .clk  (clk),
    .rst  (rst),
    .en   (en),
    .vin  (in_valid),
    .din  (in_data),
    .vout (f_vld),
    .tag  (f_tag),
    .sq   (f_sq)
  );

  // distance from centre
  ppp_isqrt u_isqrt (
    .clk     (clk),
    .rst     (rst),
    .en      (en),
    .vin     (f_vld),
    .sq      (f_sq),
    .tag_in  (f_tag),
    .vout    (s_vld),
    .root    (s_root),
    .tag_out (s_tag)
  );

  // threshold check and rounded offsets |v|*|r|/d
  ppp_div u_div (
    .clk          (clk),
    .rst          (rst),
    .en           (en),
    .vin          (s_vld),
    .root         (s_root),
    .tag_in       (s_tag),
    .min_distance (min_distance),
    .vout         (d_vld),
    .quo          (d_quo),
    .tag_out      (d_tag)
  );

  // result beat register
  ppp_back u_back (
    .clk  (clk),
    .rst  (rst),
    .en   (en),
    .vin  (d_vld),
    .quo  (d_quo),
    .tag  (d_tag),
    .vout (out_valid),
    .data (out_data)
  );

endmodule
`default_nettype wire

// File: bench/project_point_onto_line_or_circle_tb.sv
// testbench: directed table and random beats checked against a projection predictor
`timescale 1ns / 1ps
`default_nettype none
module project_point_onto_line_or_circle_tb;
  import ppp_pkg::*;

  localparam int N_RANDOM  = 1550;
  localparam int LATENCY   = 72;
  localparam int QUIET_TAIL = 300;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  ppp_in_t     in_data;
  logic        out_valid;
  logic        out_ready;
  ppp_out_t    out_data;
  logic        cfg_wr_en;
  logic [16:0] cfg_wr_data;

  // directed row: beat, and an optional typed-in expected result
  typedef struct {
    ppp_in_t  beat;
    logic     fixed;
    ppp_out_t want;
  } row_t;

  ppp_out_t    proj_queue[$];
  logic [16:0] min_dist_model;
  int          fail_count;
  int          sent_count;
  int          got_count;
  bit          calm;
  row_t        rows[$];

  project_point_onto_line_or_circle dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // saturate to the 32-bit signed range
  function automatic logic signed [31:0] clip32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) return 32'sh7fff_ffff;
    if (v < -64'sd2147483648) return 32'sh8000_0000;
    return v[31:0];
  endfunction

  // q16 product, rounded by adding a half and flooring
  function automatic logic signed [63:0] qmul(input logic signed [31:0] a,
                                              input logic signed [31:0] b);
    logic signed [63:0] p;
    p = 64'(a) * 64'(b) + 64'sd32768;
    return p >>> 16;
  endfunction

  function automatic logic [63:0] root64(input logic [63:0] n);
    logic [63:0] res;
    logic [63:0] bitv;
    res  = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (n >= res + bitv) begin
        n   = n - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  // centre plus v scaled by r over d, rounded half away from zero
  function automatic logic signed [31:0] scale_coord(input logic signed [31:0] c,
                                                     input logic signed [32:0] v,
                                                     input logic signed [31:0] r,
                                                     input logic [63:0] d);
    logic [63:0] mv;
    logic [63:0] mr;
    logic [63:0] q;
    logic signed [63:0] s;
    mv = v < 0 ? 64'(-v) : 64'(v);
    mr = r < 0 ? 64'(-64'(r)) : 64'(r);
    q  = (mv * mr + d / 2) / d;
    if (q > (64'd1 << 33)) q = 64'd1 << 33;
    if ((v < 0) != (r < 0)) s = 64'(c) - $signed(q);
    else s = 64'(c) + $signed(q);
    return clip32(s);
  endfunction

  function automatic ppp_out_t project(input ppp_in_t b);
    ppp_out_t o;
    logic signed [31:0] t;
    logic signed [32:0] vx;
    logic signed [32:0] vy;
    logic [63:0] ux;
    logic [63:0] uy;
    logic [63:0] d;
    logic shr;
    o.proj_valid = 1'b1;
    if (b.op == OP_LINE) begin
      t = clip32(qmul(b.shape_b, b.point_x) - qmul(b.shape_a, b.point_y));
      o.proj_x = clip32(qmul(b.shape_a, b.shape_c) + qmul(b.shape_b, t));
      o.proj_y = clip32(qmul(b.shape_b, b.shape_c) - qmul(b.shape_a, t));
    end else begin
      vx  = 33'(b.point_x) - 33'(b.shape_a);
      vy  = 33'(b.point_y) - 33'(b.shape_b);
      ux  = vx < 0 ? 64'(-vx) : 64'(vx);
      uy  = vy < 0 ? 64'(-vy) : 64'(vy);
      shr = (ux >= 64'h8000_0000) || (uy >= 64'h8000_0000);
      ux  = ux >> shr;
      uy  = uy >> shr;
      d   = root64(ux * ux + uy * uy) << shr;
      if (d == 0 || d < 64'(min_dist_model)) begin
        o = '0;
      end else begin
        o.proj_x = scale_coord(b.shape_a, vx, b.shape_c, d);
        o.proj_y = scale_coord(b.shape_b, vy, b.shape_c, d);
      end
    end
    return o;
  endfunction

  function automatic logic [31:0] rnd_word();
    // bias towards extremes and small values now and then
    case ($urandom_range(0, 7))
      0: return 32'h7fff_ffff;
      1: return 32'h8000_0000;
      2: return 32'($signed($urandom_range(0, 8)) - 4) <<< 16;
      3: return 32'($urandom_range(0, 131072)) - 32'd65536;
      default: return $urandom;
    endcase
  endfunction

  function automatic ppp_in_t rnd_beat();
    ppp_in_t b;
    logic signed [31:0] ang;
    b.op      = 1'($urandom_range(0, 1));
    b.shape_a = rnd_word();
    b.shape_b = rnd_word();
    b.shape_c = rnd_word();
    b.point_x = rnd_word();
    b.point_y = rnd_word();
    // mostly realistic shapes: unit-ish normals, points near the centre
    if ($urandom_range(0, 3) != 0) begin
      if (b.op == OP_LINE) begin
        ang = $signed($urandom_range(0, 131072)) - 65536;
        b.shape_a = ang;
        b.shape_b = ($urandom_range(0, 1) ? 1 : -1) * (65536 - (ang < 0 ? -ang : ang));
      end else begin
        b.point_x = b.shape_a + ($signed($urandom_range(0, 8)) - 4);
        if ($urandom_range(0, 1)) b.point_y = b.shape_b + ($signed($urandom_range(0, 8)) - 4);
      end
    end
    return b;
  endfunction

  function automatic row_t mk(input logic op, input logic [31:0] a, input logic [31:0] b,
                              input logic [31:0] c, input logic [31:0] x,
                              input logic [31:0] y, input logic fixed,
                              input logic [31:0] wx, input logic [31:0] wy,
                              input logic wv);
    row_t r;
    r.beat  = '{op: op, shape_a: a, shape_b: b, shape_c: c, point_x: x, point_y: y};
    r.fixed = fixed;
    r.want  = '{proj_x: wx, proj_y: wy, proj_valid: wv};
    return r;
  endfunction

  // one beat into the block, with random idling beforehand
  // valid is left high on return so beats can follow back to back
  task automatic send_beat(input ppp_in_t b);
    int gap;
    if (!calm && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 19);
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_data  <= b;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    proj_queue.push_back(project(b));
    sent_count++;
    @(negedge clk);
  endtask

  // wait for every result, plus the pipeline depth for safety
  task automatic drain();
    in_valid <= 1'b0;
    while (proj_queue.size() != 0) @(negedge clk);
    repeat (LATENCY + 4) @(negedge clk);
  endtask

  task automatic set_min_dist(input logic [16:0] v);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    min_dist_model = v;
  endtask

  task automatic exp_beat_chk(input ppp_out_t e);
    if (out_data.proj_x !== e.proj_x) begin
      $error("proj_x expected %h actual %h", e.proj_x, out_data.proj_x);
      fail_count++;
    end
    if (out_data.proj_y !== e.proj_y) begin
      $error("proj_y expected %h actual %h", e.proj_y, out_data.proj_y);
      fail_count++;
    end
    if (out_data.proj_valid !== e.proj_valid) begin
      $error("proj_valid expected %b actual %b", e.proj_valid, out_data.proj_valid);
      fail_count++;
    end
  endtask

  // receiver: random stalls, compared at the rising edge
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (!calm && $urandom_range(0, 5) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 19)) @(negedge clk);
      end
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      got_count++;
      if (proj_queue.size() == 0) begin
        $error("result beat with nothing expected");
        fail_count++;
      end else begin
        exp_beat_chk(proj_queue.pop_front());
      end
    end
  end

  // watchdog
  initial begin
    #8ms;
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    ppp_out_t p;
    int k;
    rst         = 1'b1;
    in_valid    = 1'b0;
    in_data     = '0;
    cfg_wr_en   = 1'b0;
    cfg_wr_data = '0;
    fail_count  = 0;
    sent_count  = 0;
    got_count   = 0;
    calm        = 1'b0;
    min_dist_model = 17'd1;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed rows; typed-in results where obvious
    rows.push_back(mk(OP_LINE, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 1, 0, 0, 1));
    rows.push_back(mk(OP_LINE, 32'h0001_0000, 32'h0, 32'h0003_0000, 32'h0007_0000,
                      32'h0002_0000, 1, 32'h0003_0000, 32'h0002_0000, 1));
    rows.push_back(mk(OP_LINE, 32'h0, 32'h0001_0000, 32'hfffe_0000, 32'h0005_0000,
                      32'h0009_0000, 1, 32'h0005_0000, 32'hfffe_0000, 1));
    rows.push_back(mk(OP_LINE, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
                      32'h8000_0000, 32'h7fff_ffff, 0, 0, 0, 0));
    rows.push_back(mk(OP_LINE, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                      32'h8000_0000, 32'h8000_0000, 0, 0, 0, 0));
    rows.push_back(mk(OP_LINE, 32'hffff_ffff, 32'h0000_8000, 32'h0000_8000,
                      32'h0000_0001, 32'hffff_ffff, 0, 0, 0, 0));
    // point at the centre: invalid, zero outputs
    rows.push_back(mk(OP_CIRCLE, 32'h0001_0000, 32'h0002_0000, 32'h0005_0000,
                      32'h0001_0000, 32'h0002_0000, 1, 0, 0, 0));
    rows.push_back(mk(OP_CIRCLE, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff,
                      32'h8000_0000, 32'h7fff_ffff, 1, 0, 0, 0));
    rows.push_back(mk(OP_CIRCLE, 32'h0, 32'h0, 32'h0002_0000, 32'h0005_0000, 32'h0,
                      1, 32'h0002_0000, 32'h0, 1));
    // negative radius lands opposite
    rows.push_back(mk(OP_CIRCLE, 32'h0, 32'h0, 32'hfffe_0000, 32'h0, 32'h0003_0000,
                      1, 32'h0, 32'hfffe_0000, 1));
    rows.push_back(mk(OP_CIRCLE, 32'h0, 32'h0, 32'h0001_0000, 32'h1, 32'h0, 0, 0, 0, 0));
    // huge offsets take the halved root path
    rows.push_back(mk(OP_CIRCLE, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff,
                      32'h7fff_ffff, 32'h7fff_ffff, 0, 0, 0, 0));
    rows.push_back(mk(OP_CIRCLE, 32'h7fff_ffff, 32'h0, 32'h8000_0000,
                      32'h8000_0000, 32'h1, 0, 0, 0, 0));
    // tiny vector, huge radius: offset up to full scale, saturated where it overflows
    rows.push_back(mk(OP_CIRCLE, 32'h0, 32'h0, 32'h7fff_ffff, 32'h1, 32'h1, 0, 0, 0, 0));
    rows.push_back(mk(OP_CIRCLE, 32'h0, 32'h0, 32'h8000_0000, 32'hffff_ffff,
                      32'h0, 0, 0, 0, 0));
    rows.push_back(mk(OP_CIRCLE, 32'h0003_0000, 32'hfffd_0000, 32'h0000_8000,
                      32'h0004_0000, 32'hfffc_0000, 0, 0, 0, 0));

    foreach (rows[i]) begin
      send_beat(rows[i].beat);
      if (rows[i].fixed) begin
        p = proj_queue[$];
        if (p !== rows[i].want) begin
          $error("directed row %0d: table %h predictor %h", i, rows[i].want, p);
          fail_count++;
        end
      end
    end
    drain();

    // min_distance in phases: zero, 0x10000, a random middle value, 5 and 1
    for (k = 0; k < 5; k++) begin
      case (k)
        0: set_min_dist(17'd0);
        1: set_min_dist(17'h1_0000);
        2: set_min_dist(17'($urandom_range(2, 65535)));
        3: set_min_dist(17'h0_0005);
        default: set_min_dist(17'd1);
      endcase
      // near-centre circle beats around the threshold
      send_beat('{op: OP_CIRCLE, shape_a: 0, shape_b: 0, shape_c: 32'h0001_0000,
                  point_x: 32'(min_dist_model), point_y: 0});
      send_beat('{op: OP_CIRCLE, shape_a: 0, shape_b: 0, shape_c: 32'h0001_0000,
                  point_x: 32'(min_dist_model) - 1, point_y: 0});
      repeat (N_RANDOM / 5) begin
        if (k == 4 && sent_count > N_RANDOM - 150) calm = 1'b1;
        send_beat(rnd_beat());
      end
      drain();
    end

    $display("summary: %0d beats sent, %0d results checked over 6 min_distance settings",
             sent_count, got_count);
    $display("line and circle modes, centre cases, saturation and random stalls covered");
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
`default_nettype wire
